@@ src/assert_macros.svh @@
// Assertion macros for the RTL files of the rotation vector block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next clock cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/rmrv_pkg.sv @@
// Package of the rotation matrix to rotation vector block: widths, codes, tables, types.
// Depends on nothing; used by every module of the block except rmrv_isqrt.
`default_nettype none

package rmrv_pkg;

   localparam int ENTRY_WIDTH  = 32;
   localparam int VECTOR_WIDTH = 32;
   localparam int WORK_FRAC    = 30;
   localparam int WORK_W       = 32;   // matrix entry on the Q.30 grid
   localparam int NUM_W        = 33;   // sum or difference of two entries
   localparam int T_W          = 33;   // square root argument, below 8.0
   localparam int LANES        = 3;
   localparam int QUEUE_DEPTH  = 4;
   localparam int CORDIC_STEPS = 30;

   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
      32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535,
      32'd32767, 32'd16383, 32'd8191, 32'd4095, 32'd2047,
      32'd1023, 32'd511, 32'd255, 32'd127, 32'd63,
      32'd31, 32'd15, 32'd7, 32'd3, 32'd1
   };

   typedef struct packed {
      logic signed [ENTRY_WIDTH-1:0] m00;
      logic signed [ENTRY_WIDTH-1:0] m01;
      logic signed [ENTRY_WIDTH-1:0] m02;
      logic signed [ENTRY_WIDTH-1:0] m10;
      logic signed [ENTRY_WIDTH-1:0] m11;
      logic signed [ENTRY_WIDTH-1:0] m12;
      logic signed [ENTRY_WIDTH-1:0] m20;
      logic signed [ENTRY_WIDTH-1:0] m21;
      logic signed [ENTRY_WIDTH-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [VECTOR_WIDTH-1:0] vec_x;
      logic signed [VECTOR_WIDTH-1:0] vec_y;
      logic signed [VECTOR_WIDTH-1:0] vec_z;
   } rsp_type;

   // Classified matrix: branch, square root argument and the three numerators
   // of the off-branch quaternion components in w, x, y, z order.
   typedef struct packed {
      logic [1:0]                  br;
      logic [T_W-1:0]              t;
      logic [LANES-1:0][NUM_W-1:0] num;
   } front_type;

endpackage

`default_nettype wire

@@ src/rotation_matrix_to_rotation_vector.sv @@
// Rotation matrix to rotation vector (axis times angle). Each transaction on
// the req_ side carries one 3x3 matrix, row-major, signed Q1.30 entries; each
// transaction on the rsp_ side returns the rotation vector as three signed
// Q3.28 components, saturated, one result per matrix and in order. The block
// takes one matrix per clock cycle while the queue is not full. The path
// runs through one front-end register, the decoupling queue, two 32-stage
// square roots (quaternion diagonal and vector-part norm), two 32-stage
// dividers (off-diagonal components and final scale), a 30-stage CORDIC
// arctangent, and five register stages for quaternion assembly, squaring,
// summing, scaling and the output register. The back pipeline
// advances as a whole and holds when the output register is full and stalled;
// the queue lets the front end keep taking matrices during such stalls.
// Depends on rmrv_pkg, rmrv_front, rmrv_queue, rmrv_isqrt, rmrv_div, rmrv_cordic.
`default_nettype none

module rotation_matrix_to_rotation_vector (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire rmrv_pkg::req_type  req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rmrv_pkg::rsp_type       rsp_payload
);

   localparam int L   = rmrv_pkg::LANES;
   localparam int VW  = rmrv_pkg::VECTOR_WIDTH;
   localparam int VF  = VW - 4;
   localparam int SHL = (VF >= rmrv_pkg::WORK_FRAC) ? VF - rmrv_pkg::WORK_FRAC : 0;
   localparam int SHR = (VF < rmrv_pkg::WORK_FRAC) ? rmrv_pkg::WORK_FRAC - VF : 0;
   localparam logic [63:0] LIM = (64'd1 << (VW - 1)) - 64'd1;

   // Sideband records carried alongside each arithmetic unit.
   typedef struct packed {
      logic [1:0]                            br;
      logic [L-1:0][rmrv_pkg::NUM_W-1:0]     num;
   } sq1_side_type;

   typedef struct packed {
      logic [1:0]   br;
      logic [L-1:0] neg;
      logic [30:0]  qd;
   } dv1_side_type;

   typedef struct packed {
      logic [31:0]         qw;
      logic [L-1:0][31:0]  mag;
      logic [L-1:0]        neg;
   } quat_type;

   typedef struct packed {
      logic [31:0]         n;
      logic [L-1:0][31:0]  mag;
      logic [L-1:0]        neg;
   } cor_side_type;

   typedef struct packed {
      logic                nzero;
      logic [L-1:0][31:0]  mag;
      logic [L-1:0]        neg;
   } dv2_side_type;

   // Front end and queue.
   logic                 push_valid, q_full, q_empty, pop, back_en;
   rmrv_pkg::front_type  push_data, head;

   rmrv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   rmrv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .head      (head)
   );

   // The whole back pipeline moves one step whenever the output register
   // is free or being emptied in this cycle.
   logic rsp_valid_ff;
   assign back_en = !rsp_valid_ff || !rsp_stall;
   assign pop     = !q_empty && back_en;

   // Square root of T on the Q.30 grid gives sqrt(T); s is twice that.
   sq1_side_type sq1_in_side, sq1_out_side;
   logic         sq1_valid;
   logic [31:0]  sq;

   assign sq1_in_side.br  = head.br;
   assign sq1_in_side.num = head.num;

   rmrv_isqrt #(.VW(64), .SBW($bits(sq1_side_type))) u_sqrt_t (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (pop),
      .in_value  ({1'b0, head.t, 30'd0}),
      .in_side   (sq1_in_side),
      .out_valid (sq1_valid),
      .out_root  (sq),
      .out_side  (sq1_out_side)
   );

   // Off-diagonal components: |numerator| * 2^30 / s, sign restored later.
   dv1_side_type           dv1_in_side, dv1_out_side;
   logic [L-1:0][62:0]     dv1_num;
   logic [L-1:0][31:0]     dv1_quo;
   logic                   dv1_valid;

   always_comb begin
      dv1_in_side.br = sq1_out_side.br;
      dv1_in_side.qd = sq[31:1];
      for (int j = 0; j < L; j++) begin
         dv1_in_side.neg[j] = sq1_out_side.num[j][rmrv_pkg::NUM_W-1];
         if (sq1_out_side.num[j][rmrv_pkg::NUM_W-1]) begin
            dv1_num[j] = {(-sq1_out_side.num[j]), 30'd0};
         end else begin
            dv1_num[j] = {sq1_out_side.num[j], 30'd0};
         end
      end
   end

   rmrv_div #(.DW(63), .SW(33), .QW(32), .SBW($bits(dv1_side_type))) u_div_q (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (sq1_valid),
      .in_num    (dv1_num),
      .in_den    ({sq, 1'b0}),
      .in_side   (dv1_in_side),
      .out_valid (dv1_valid),
      .out_quo   (dv1_quo),
      .out_side  (dv1_out_side)
   );

   // Assemble the quaternion by branch, force qw to be non-negative and
   // split the vector part into magnitudes and signs.
   logic signed [32:0] v0, v1, v2, qdv, w, x, y, z, wf, xf, yf, zf;
   logic signed [32:0] ax, ay, az;
   quat_type           quat_in, quat_ff;
   logic               quat_vld_ff;

   assign v0  = dv1_out_side.neg[0] ? -$signed({1'b0, dv1_quo[0]}) : $signed({1'b0, dv1_quo[0]});
   assign v1  = dv1_out_side.neg[1] ? -$signed({1'b0, dv1_quo[1]}) : $signed({1'b0, dv1_quo[1]});
   assign v2  = dv1_out_side.neg[2] ? -$signed({1'b0, dv1_quo[2]}) : $signed({1'b0, dv1_quo[2]});
   assign qdv = $signed({2'b00, dv1_out_side.qd});

   always_comb begin
      case (dv1_out_side.br)
         rmrv_pkg::BR_TRACE: begin
            w = qdv; x = v0; y = v1; z = v2;
         end
         rmrv_pkg::BR_X: begin
            w = v0; x = qdv; y = v1; z = v2;
         end
         rmrv_pkg::BR_Y: begin
            w = v0; x = v1; y = qdv; z = v2;
         end
         default: begin
            w = v0; x = v1; y = v2; z = qdv;
         end
      endcase
      if (w[32]) begin
         wf = -w; xf = -x; yf = -y; zf = -z;
      end else begin
         wf = w; xf = x; yf = y; zf = z;
      end
      ax = xf[32] ? -xf : xf;
      ay = yf[32] ? -yf : yf;
      az = zf[32] ? -zf : zf;
      quat_in.qw  = wf[31:0];
      quat_in.mag = {az[31:0], ay[31:0], ax[31:0]};
      quat_in.neg = {zf[32], yf[32], xf[32]};
   end

   // Squares of the vector part, then their sum.
   logic [L-1:0][63:0] sqr_ff;
   quat_type           sqr_quat_ff;
   logic               sqr_vld_ff;
   logic [63:0]        sum_ff;
   quat_type           sum_quat_ff;
   logic               sum_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_vld_ff <= 1'b0;
         sqr_vld_ff  <= 1'b0;
         sum_vld_ff  <= 1'b0;
      end else if (back_en) begin
         quat_vld_ff <= dv1_valid;
         sqr_vld_ff  <= quat_vld_ff;
         sum_vld_ff  <= sqr_vld_ff;
      end
      if (back_en) begin
         quat_ff     <= quat_in;
         for (int j = 0; j < L; j++) begin
            sqr_ff[j] <= 64'(quat_ff.mag[j]) * 64'(quat_ff.mag[j]);
         end
         sqr_quat_ff <= quat_ff;
         sum_ff      <= sqr_ff[0] + sqr_ff[1] + sqr_ff[2];
         sum_quat_ff <= sqr_quat_ff;
      end
   end

   // Norm of the vector part.
   quat_type     sq2_out_side;
   logic         sq2_valid;
   logic [31:0]  n;

   rmrv_isqrt #(.VW(64), .SBW($bits(quat_type))) u_sqrt_n (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (sum_vld_ff),
      .in_value  (sum_ff),
      .in_side   (sum_quat_ff),
      .out_valid (sq2_valid),
      .out_root  (n),
      .out_side  (sq2_out_side)
   );

   // Half angle as atan2(n, qw).
   cor_side_type       cor_in_side, cor_out_side;
   logic               cor_valid;
   logic signed [33:0] angle;

   assign cor_in_side.n   = n;
   assign cor_in_side.mag = sq2_out_side.mag;
   assign cor_in_side.neg = sq2_out_side.neg;

   rmrv_cordic #(.SBW($bits(cor_side_type))) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (sq2_valid),
      .in_y      (n),
      .in_x      (sq2_out_side.qw),
      .in_side   (cor_in_side),
      .out_valid (cor_valid),
      .out_angle (angle),
      .out_side  (cor_out_side)
   );

   // Full angle times each magnitude. A zero norm leaves the angle at zero,
   // and a negative angle clamps to zero.
   logic               nz;
   logic [31:0]        ang2;
   logic [L-1:0][63:0] prod_ff;
   logic [31:0]        prod_n_ff;
   dv2_side_type       prod_side_ff;
   logic               prod_vld_ff;

   assign nz   = cor_out_side.n == '0;
   assign ang2 = (nz || angle[33]) ? '0 : {angle[30:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else if (back_en) begin
         prod_vld_ff <= cor_valid;
      end
      if (back_en) begin
         for (int j = 0; j < L; j++) begin
            prod_ff[j] <= 64'(ang2) * 64'(cor_out_side.mag[j]);
         end
         prod_n_ff          <= cor_out_side.n;
         prod_side_ff.nzero <= nz;
         prod_side_ff.mag   <= cor_out_side.mag;
         prod_side_ff.neg   <= cor_out_side.neg;
      end
   end

   // Scale division by the norm.
   dv2_side_type       dv2_out_side;
   logic [L-1:0][31:0] dv2_quo;
   logic               dv2_valid;

   rmrv_div #(.DW(64), .SW(32), .QW(32), .SBW($bits(dv2_side_type))) u_div_s (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (prod_vld_ff),
      .in_num    (prod_ff),
      .in_den    (prod_n_ff),
      .in_side   (prod_side_ff),
      .out_valid (dv2_valid),
      .out_quo   (dv2_quo),
      .out_side  (dv2_out_side)
   );

   // Move to the output fraction bits, restore signs and saturate.
   logic [L-1:0][VW-1:0] comp;
   logic [63:0] m_w [L];
   logic [63:0] m_sh [L];
   logic [63:0] o_w [L];
   rmrv_pkg::rsp_type rsp_payload_ff;

   always_comb begin
      for (int j = 0; j < L; j++) begin
         if (dv2_out_side.nzero) begin
            m_w[j] = 64'({dv2_out_side.mag[j], 1'b0});
         end else begin
            m_w[j] = 64'(dv2_quo[j]);
         end
         m_sh[j] = (m_w[j] << SHL) >> SHR;
         if (m_sh[j] > LIM) begin
            o_w[j] = dv2_out_side.neg[j] ? ~LIM : LIM;
         end else begin
            o_w[j] = dv2_out_side.neg[j] ? -m_sh[j] : m_sh[j];
         end
         comp[j] = o_w[j][VW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         rsp_valid_ff <= dv2_valid;
      end
      if (back_en) begin
         rsp_payload_ff.vec_x <= comp[0];
         rsp_payload_ff.vec_y <= comp[1];
         rsp_payload_ff.vec_z <= comp[2];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

@@ src/rmrv_front.sv @@
// Front end: accepts a matrix, picks the quaternion branch and forms the
// square root argument and numerators. Depends on rmrv_pkg.
`default_nettype none

module rmrv_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire rmrv_pkg::req_type    req_payload,
   input  wire logic                 q_full,
   output logic                      push_valid,
   output rmrv_pkg::front_type       push_data
);

   localparam int EF  = rmrv_pkg::ENTRY_WIDTH - 2;
   localparam int RSH = (EF >= rmrv_pkg::WORK_FRAC) ? EF - rmrv_pkg::WORK_FRAC : 0;
   localparam int LSH = (EF < rmrv_pkg::WORK_FRAC) ? rmrv_pkg::WORK_FRAC - EF : 0;
   localparam logic signed [35:0] ONE = 36'sd1 <<< rmrv_pkg::WORK_FRAC;

   function automatic logic signed [rmrv_pkg::WORK_W-1:0] to_work(
      input logic signed [rmrv_pkg::ENTRY_WIDTH-1:0] e);
      logic signed [63:0] w;
      w = 64'(e);
      return rmrv_pkg::WORK_W'((w >>> RSH) <<< LSH);
   endfunction

   logic signed [rmrv_pkg::WORK_W-1:0] r0, r1, r2, r3, r4, r5, r6, r7, r8, d;
   logic signed [33:0] tr;
   logic signed [35:0] t_full;
   logic signed [rmrv_pkg::NUM_W-1:0] da, db, dc, sa, sb, sc;
   rmrv_pkg::front_type cls;
   logic                  front_vld_ff;
   rmrv_pkg::front_type   front_data_ff;
   logic                  load;

   assign r0 = to_work(req_payload.m00);
   assign r1 = to_work(req_payload.m01);
   assign r2 = to_work(req_payload.m02);
   assign r3 = to_work(req_payload.m10);
   assign r4 = to_work(req_payload.m11);
   assign r5 = to_work(req_payload.m12);
   assign r6 = to_work(req_payload.m20);
   assign r7 = to_work(req_payload.m21);
   assign r8 = to_work(req_payload.m22);

   assign tr = 34'(r0) + 34'(r4) + 34'(r8);
   assign da = 33'(r7) - 33'(r5);
   assign db = 33'(r2) - 33'(r6);
   assign dc = 33'(r3) - 33'(r1);
   assign sa = 33'(r1) + 33'(r3);
   assign sb = 33'(r2) + 33'(r6);
   assign sc = 33'(r5) + 33'(r7);

   always_comb begin
      if (tr > 34'sd0) begin
         cls.br = rmrv_pkg::BR_TRACE;
         d      = r0;
      end else if (r0 > r4 && r0 > r8) begin
         cls.br = rmrv_pkg::BR_X;
         d      = r0;
      end else if (r4 > r8) begin
         cls.br = rmrv_pkg::BR_Y;
         d      = r4;
      end else begin
         cls.br = rmrv_pkg::BR_Z;
         d      = r8;
      end
      if (cls.br == rmrv_pkg::BR_TRACE) begin
         t_full = ONE + 36'(tr);
      end else begin
         t_full = ONE + (36'(d) <<< 1) - 36'(tr);
      end
      cls.t = t_full[35] ? '0 : t_full[rmrv_pkg::T_W-1:0];
      case (cls.br)
         rmrv_pkg::BR_TRACE: cls.num = {dc, db, da};
         rmrv_pkg::BR_X:     cls.num = {sb, sa, da};
         rmrv_pkg::BR_Y:     cls.num = {sc, sa, db};
         default:            cls.num = {sc, sb, dc};
      endcase
   end

   assign load       = !front_vld_ff || !q_full;
   assign req_stall  = !load;
   assign push_valid = front_vld_ff && !q_full;
   assign push_data  = front_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else if (load) begin
         front_vld_ff <= req_valid;
      end
      if (load) begin
         front_data_ff <= cls;
      end
   end

endmodule

`default_nettype wire

@@ src/rmrv_queue.sv @@
// Short queue between the front end and the arithmetic pipeline.
// Depends on rmrv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rmrv_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire rmrv_pkg::front_type  push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      empty,
   output rmrv_pkg::front_type       head
);

   localparam int DEPTH = rmrv_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNTW  = AW + 1;

   rmrv_pkg::front_type slot_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNTW-1:0] count_ff;
   logic            push_ok, pop_ok;

   assign full    = count_ff == CNTW'(DEPTH);
   assign empty   = count_ff == '0;
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNTW'(DEPTH))
   `ASSERT_ALWAYS(a_ptr_count, clock, reset, AW'(wr_ptr_ff - rd_ptr_ff) == count_ff[AW-1:0])
   `ASSERT_NEXT(a_push_grows, clock, reset, push_ok && !pop_ok, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

@@ src/rmrv_isqrt.sv @@
// Pipelined integer square root, one result bit per stage, with a sideband.
// Depends on nothing beyond its parameters.
`default_nettype none

module rmrv_isqrt #(
   parameter int VW  = 64,
   parameter int SBW = 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire logic [VW-1:0]   in_value,
   input  wire logic [SBW-1:0]  in_side,
   output logic                 out_valid,
   output logic [VW/2-1:0]      out_root,
   output logic [SBW-1:0]       out_side
);

   localparam int RW = VW / 2;
   localparam int MW = RW + 3;

   logic           vld_ff  [RW];
   logic [MW-1:0]  rem_ff  [RW];
   logic [RW-1:0]  root_ff [RW];
   logic [VW-1:0]  val_ff  [RW];
   logic [SBW-1:0] side_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic           vld_p;
      logic [MW-1:0]  rem_p, rem_sh, trial, rem_in;
      logic [RW-1:0]  root_p, root_in;
      logic [VW-1:0]  val_p;
      logic [SBW-1:0] side_p;

      if (k == 0) begin : g_head
         assign vld_p  = in_valid;
         assign rem_p  = '0;
         assign root_p = '0;
         assign val_p  = in_value;
         assign side_p = in_side;
      end else begin : g_body
         assign vld_p  = vld_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign val_p  = val_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign rem_sh = {rem_p[MW-3:0], val_p[VW-1:VW-2]};
      assign trial  = {1'b0, root_p, 2'b01};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_p[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_p[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            val_ff[k]  <= {val_p[VW-3:0], 2'b00};
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

`default_nettype wire

@@ src/rmrv_div.sv @@
// Pipelined restoring divider, three lanes over one shared divisor, one
// quotient bit per stage. Depends on rmrv_pkg.
`default_nettype none

module rmrv_div #(
   parameter int DW  = 64,
   parameter int SW  = 32,
   parameter int QW  = 32,
   parameter int SBW = 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                en,
   input  wire logic                                in_valid,
   input  wire logic [rmrv_pkg::LANES-1:0][DW-1:0]  in_num,
   input  wire logic [SW-1:0]                       in_den,
   input  wire logic [SBW-1:0]                      in_side,
   output logic                                     out_valid,
   output logic [rmrv_pkg::LANES-1:0][QW-1:0]       out_quo,
   output logic [SBW-1:0]                           out_side
);

   localparam int L = rmrv_pkg::LANES;

   logic                  vld_ff  [QW];
   logic [L-1:0][SW-1:0]  rem_ff  [QW];
   logic [L-1:0][QW-1:0]  lo_ff   [QW];
   logic [L-1:0][QW-1:0]  quo_ff  [QW];
   logic [SW-1:0]         den_ff  [QW];
   logic [SBW-1:0]        side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic                  vld_p;
      logic [L-1:0][SW-1:0]  rem_p, rem_in;
      logic [L-1:0][QW-1:0]  lo_p, quo_p, quo_in;
      logic [L-1:0][SW:0]    rem_sh;
      logic [SW-1:0]         den_p;
      logic [SBW-1:0]        side_p;

      if (k == 0) begin : g_head
         assign vld_p  = in_valid;
         assign den_p  = in_den;
         assign side_p = in_side;
         assign quo_p  = '0;
         for (genvar j = 0; j < L; j++) begin : g_lane
            assign rem_p[j] = SW'(in_num[j] >> QW);
            assign lo_p[j]  = in_num[j][QW-1:0];
         end
      end else begin : g_body
         assign vld_p  = vld_ff[k-1];
         assign den_p  = den_ff[k-1];
         assign side_p = side_ff[k-1];
         assign quo_p  = quo_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign lo_p   = lo_ff[k-1];
      end

      always_comb begin
         for (int j = 0; j < L; j++) begin
            rem_sh[j] = {rem_p[j], lo_p[j][QW-1]};
            if (rem_sh[j] >= {1'b0, den_p}) begin
               rem_in[j] = SW'(rem_sh[j] - {1'b0, den_p});
               quo_in[j] = {quo_p[j][QW-2:0], 1'b1};
            end else begin
               rem_in[j] = rem_sh[j][SW-1:0];
               quo_in[j] = {quo_p[j][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_p;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            lo_ff[k]   <= lo_p << 1;
            den_ff[k]  <= den_p;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

`default_nettype wire

@@ src/rmrv_cordic.sv @@
// Pipelined CORDIC vectoring unit giving atan2(y, x) on the Q.30 grid,
// one rotation per stage, with a sideband. Depends on rmrv_pkg.
`default_nettype none

module rmrv_cordic #(
   parameter int SBW = 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire logic [31:0]     in_y,
   input  wire logic [31:0]     in_x,
   input  wire logic [SBW-1:0]  in_side,
   output logic                 out_valid,
   output logic signed [33:0]   out_angle,
   output logic [SBW-1:0]       out_side
);

   localparam int N  = rmrv_pkg::CORDIC_STEPS;
   localparam int XW = 36;
   localparam int ZW = 34;

   logic                 vld_ff  [N];
   logic signed [XW-1:0] x_ff    [N];
   logic signed [XW-1:0] y_ff    [N];
   logic signed [ZW-1:0] z_ff    [N];
   logic [SBW-1:0]       side_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic                 vld_p, pos;
      logic signed [XW-1:0] x_p, y_p, x_in, y_in;
      logic signed [ZW-1:0] z_p, z_in, step;
      logic [SBW-1:0]       side_p;

      if (i == 0) begin : g_head
         assign vld_p  = in_valid;
         assign x_p    = XW'({1'b0, in_x});
         assign y_p    = XW'({1'b0, in_y});
         assign z_p    = '0;
         assign side_p = in_side;
      end else begin : g_body
         assign vld_p  = vld_ff[i-1];
         assign x_p    = x_ff[i-1];
         assign y_p    = y_ff[i-1];
         assign z_p    = z_ff[i-1];
         assign side_p = side_ff[i-1];
      end

      assign pos  = y_p > 0;
      assign step = ZW'(rmrv_pkg::ATAN_TAB[i]);

      always_comb begin
         if (pos) begin
            x_in = x_p + (y_p >>> i);
            y_in = y_p - (x_p >>> i);
            z_in = z_p + step;
         end else begin
            x_in = x_p - (y_p >>> i);
            y_in = y_p + (x_p >>> i);
            z_in = z_p - step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_p;
         end
         if (en) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_angle = z_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

`default_nettype wire

@@ sim/rmrv_checker.sv @@
// Checker for the rotation matrix to rotation vector block: watches both channels,
// predicts each rotation vector and compares it field by field. Depends on rmrv_pkg.
module rmrv_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire rmrv_pkg::req_type req_payload,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire rmrv_pkg::rsp_type rsp_payload,
   output int                     failures,
   output int                     pending_vectors,
   output int                     vectors_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   rmrv_pkg::rsp_type expected_vectors[$];

   // Arctangent table in Q.30, truncated.
   localparam longint ANGLE_TABLE [30] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
      127, 63, 31, 15, 7, 3, 1};

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Quotient num * 2^30 / den, truncated toward zero.
   function automatic longint frac_div(longint num, longint den);
      longint unsigned mag, q;
      if (den <= 0) return 0;
      mag = num < 0 ? -num : num;
      q = (mag << 30) / den;
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += ANGLE_TABLE[i];
         end else begin
            x -= dx; y += dy; z -= ANGLE_TABLE[i];
         end
      end
      return z;
   endfunction

   // Scales one quaternion component to the Q3.28 output with saturation.
   function automatic logic [31:0] scale_component(longint q, longint ang2,
                                                  longint unsigned n);
      longint unsigned mag, m;
      mag = q < 0 ? -q : q;
      m = (n == 0) ? mag * 2 : (longint'(ang2) * mag) / n;
      m >>= 2;
      if (m > 64'h7fff_ffff) return q < 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      return q < 0 ? 32'(-longint'(m)) : 32'(m);
   endfunction

   function automatic rmrv_pkg::rsp_type predict_vector(rmrv_pkg::req_type mat);
      longint r[9];
      longint tr, t, sq, s, qd, qw, qx, qy, qz, ang2;
      longint unsigned n;
      rmrv_pkg::rsp_type v;
      r[0] = mat.m00; r[1] = mat.m01; r[2] = mat.m02;
      r[3] = mat.m10; r[4] = mat.m11; r[5] = mat.m12;
      r[6] = mat.m20; r[7] = mat.m21; r[8] = mat.m22;
      tr = r[0] + r[4] + r[8];
      if (tr > 0) t = (64'sd1 << 30) + tr;
      else if (r[0] > r[4] && r[0] > r[8]) t = (64'sd1 << 30) + 2 * r[0] - tr;
      else if (r[4] > r[8]) t = (64'sd1 << 30) + 2 * r[4] - tr;
      else t = (64'sd1 << 30) + 2 * r[8] - tr;
      if (t < 0) t = 0;
      sq = int_sqrt(t << 30);
      s = 2 * sq;
      qd = sq >>> 1;
      if (tr > 0) begin
         qw = qd;
         qx = frac_div(r[7] - r[5], s);
         qy = frac_div(r[2] - r[6], s);
         qz = frac_div(r[3] - r[1], s);
      end else if (r[0] > r[4] && r[0] > r[8]) begin
         qw = frac_div(r[7] - r[5], s);
         qx = qd;
         qy = frac_div(r[1] + r[3], s);
         qz = frac_div(r[2] + r[6], s);
      end else if (r[4] > r[8]) begin
         qw = frac_div(r[2] - r[6], s);
         qx = frac_div(r[1] + r[3], s);
         qy = qd;
         qz = frac_div(r[5] + r[7], s);
      end else begin
         qw = frac_div(r[3] - r[1], s);
         qx = frac_div(r[2] + r[6], s);
         qy = frac_div(r[5] + r[7], s);
         qz = qd;
      end
      if (qw < 0) begin
         qw = -qw; qx = -qx; qy = -qy; qz = -qz;
      end
      n = int_sqrt(qx * qx + qy * qy + qz * qz);
      ang2 = (n != 0) ? 2 * vector_angle(longint'(n), qw) : 0;
      if (ang2 < 0) ang2 = 0;
      v.vec_x = scale_component(qx, ang2, n);
      v.vec_y = scale_component(qy, ang2, n);
      v.vec_z = scale_component(qz, ang2, n);
      return v;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      failures++;
   endtask

   initial begin
      failures = 0;
      vectors_seen = 0;
      pending_vectors = 0;
   end

   always @(posedge clock) begin
      rmrv_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) expected_vectors.push_back(predict_vector(req_payload));
         if (rsp_valid && !rsp_stall) begin
            vectors_seen++;
            if (expected_vectors.size() == 0) begin
               $display("unexpected rotation vector at %0t", $realtime);
               failures++;
            end else begin
               want = expected_vectors.pop_front();
               if (rsp_payload.vec_x !== want.vec_x)
                  report_mismatch("vec_x", rsp_payload.vec_x, want.vec_x);
               if (rsp_payload.vec_y !== want.vec_y)
                  report_mismatch("vec_y", rsp_payload.vec_y, want.vec_y);
               if (rsp_payload.vec_z !== want.vec_z)
                  report_mismatch("vec_z", rsp_payload.vec_z, want.vec_z);
            end
         end
         pending_vectors = expected_vectors.size();
      end
   end
endmodule

@@ sim/rotation_matrix_to_rotation_vector_test.sv @@
// Top of the rotation vector testbench: clock, reset, matrix stimulus and the verdict.
// Depends on rmrv_pkg, the block and the rmrv_checker module.
module rotation_matrix_to_rotation_vector_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_MATRICES = 400;
   localparam longint CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rmrv_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rmrv_pkg::rsp_type rsp_payload;
   int failures, pending_vectors, vectors_seen;
   longint cycle_count = 0;
   int matrices_sent = 0;

   rotation_matrix_to_rotation_vector DUT (.*);

   rmrv_checker checker_unit (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The watchdog ends any run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // The receiver stalls for a random hold before each result; in one draw
   // of four the stall is skipped outright.
   initial begin
      int hold;
      repeat (10) @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Sends one matrix, after a random idle gap when with_gaps is set. valid stays high between
   // back-to-back transactions, so it is never lowered and raised in one step.
   task automatic send_matrix(rmrv_pkg::req_type mat, bit with_gaps);
      int gap;
      gap = with_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= mat;
      do @(posedge clock); while (req_stall);
      matrices_sent++;
   endtask

   function automatic logic [31:0] random_entry();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h4000_0000;
         2: return 32'hc000_0000;
         3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return 32'($signed($urandom) >>> $urandom_range(1, 20));
      endcase
   endfunction

   // A near-rotation: a rotation about one axis by a random angle, with noise.
   function automatic rmrv_pkg::req_type random_rotation();
      real ang, c, sn;
      int axis;
      logic [31:0] e [9];
      ang = (($urandom % 20001) / 10000.0 - 1.0) * 3.14159265;
      c = $cos(ang);
      sn = $sin(ang);
      axis = $urandom_range(0, 2);
      foreach (e[i]) e[i] = 0;
      e[axis * 4] = 32'h4000_0000;
      e[((axis + 1) % 3) * 4] = 32'($rtoi(c * 1073741823.0));
      e[((axis + 2) % 3) * 4] = 32'($rtoi(c * 1073741823.0));
      e[((axis + 1) % 3) * 3 + (axis + 2) % 3] = 32'($rtoi(-sn * 1073741823.0));
      e[((axis + 2) % 3) * 3 + (axis + 1) % 3] = 32'($rtoi(sn * 1073741823.0));
      foreach (e[i]) e[i] = e[i] + 32'($signed($urandom_range(0, 64)) - 32);
      return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
   endfunction

   initial begin
      rmrv_pkg::req_type mat;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed matrices: identity (zero vector part), half turns about each
      // axis, diagonal ties, all-extreme entries and all-zero.
      send_matrix({32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'h4000_0000, 32'd0,
                   32'd0, 32'd0, 32'h4000_0000}, 1'b0);
      send_matrix({32'h4000_0000, 32'd0, 32'd0, 32'd0, 32'hc000_0000, 32'd0,
                   32'd0, 32'd0, 32'hc000_0000}, 1'b0);
      send_matrix({32'hc000_0000, 32'd0, 32'd0, 32'd0, 32'h4000_0000, 32'd0,
                   32'd0, 32'd0, 32'hc000_0000}, 1'b0);
      send_matrix({32'hc000_0000, 32'd0, 32'd0, 32'd0, 32'hc000_0000, 32'd0,
                   32'd0, 32'd0, 32'h4000_0000}, 1'b0);
      send_matrix({9{32'hc000_0000}}, 1'b0);
      send_matrix({9{32'd0}}, 1'b0);
      send_matrix({9{32'h7fff_ffff}}, 1'b0);
      send_matrix({9{32'h8000_0000}}, 1'b0);
      send_matrix({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h8000_0000}, 1'b0);
      send_matrix({32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                   32'hffff_ffff, 32'haaaa_aaaa, 32'h0000_0001, 32'hffff_fffe,
                   32'hc000_0001}, 1'b1);
      // Diagonal tie between m11 and m22 with a negative trace.
      send_matrix({32'hc000_0000, 32'h1000_0000, 32'd0, 32'h2000_0000, 32'd0,
                   32'h0100_0000, 32'd0, 32'h0300_0000, 32'd0}, 1'b1);

      // Let the pipeline drain completely once before the random part.
      req_valid <= 1'b0;
      while (pending_vectors != 0) @(posedge clock);

      for (int k = 0; k < RANDOM_MATRICES; k++) begin
         if ($urandom_range(0, 3) != 0) begin
            mat = random_rotation();
         end else begin
            mat = {random_entry(), random_entry(), random_entry(), random_entry(),
                   random_entry(), random_entry(), random_entry(), random_entry(),
                   random_entry()};
         end
         // Alternate stretches of back-to-back matrices with gapped ones.
         send_matrix(mat, (k / 50) % 2 == 1);
      end
      req_valid <= 1'b0;

      while (pending_vectors != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d matrices (rotations, half turns, ties, extreme patterns)",
               matrices_sent);
      $display("checked %0d rotation vectors under random stalls", vectors_seen);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
